// ===== src/assert_macros.svh =====
// Assertion macros shared by the formatter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define I2A_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define I2A_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/i2a_pkg.sv =====
// Package with the format codes, queue entry type and character tables of the formatter.
`default_nettype none

package i2a_pkg;

   // Input kind codes.
   localparam logic [2:0] KIND_SDEC = 3'd0;
   localparam logic [2:0] KIND_UDEC = 3'd1;
   localparam logic [2:0] KIND_HEXL = 3'd2;
   localparam logic [2:0] KIND_HEXU = 3'd3;
   localparam logic [2:0] KIND_PTR  = 3'd4;

   // Internal format classes.
   localparam logic [1:0] FMT_DEC  = 2'd0;
   localparam logic [1:0] FMT_HEXL = 2'd1;
   localparam logic [1:0] FMT_HEXU = 2'd2;
   localparam logic [1:0] FMT_PTR  = 2'd3;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // ASCII codes used in prefixes.
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   // One classified item waiting for the back end.
   typedef struct packed {
      logic [1:0]  fmt;
      logic        neg;
      logic        nil;
      logic [63:0] value;
   } q_entry_type;

   // Character for one digit nibble in the given format.
   function automatic logic [7:0] digit_char(input logic [1:0] fmt, input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'd0, nib};
      end else if (fmt == FMT_HEXU) begin
         ch = CH_UPPER_A + {4'd0, nib - 4'd10};
      end else begin
         ch = CH_LOWER_A + {4'd0, nib - 4'd10};
      end
      return ch;
   endfunction

   // Character at one position of the prefix: "(nil)", "0x" or "-".
   function automatic logic [7:0] prefix_char(input logic nil, input logic neg,
                                              input logic [2:0] idx);
      logic [7:0] ch;
      ch = CH_MINUS;
      if (nil) begin
         case (idx)
            3'd0:    ch = CH_LPAREN;
            3'd1:    ch = CH_N;
            3'd2:    ch = CH_I;
            3'd3:    ch = CH_L;
            default: ch = CH_RPAREN;
         endcase
      end else if (!neg) begin
         ch = (idx == 3'd0) ? CH_ZERO : CH_X;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== src/i2a_front.sv =====
// Front end: classifies each accepted item and drops undefined kinds.
`default_nettype none

module i2a_front
   import i2a_pkg::*;
(
   input  wire logic        req_valid,
   input  wire logic [2:0]  req_kind,
   input  wire logic [63:0] req_value,
   input  wire logic        q_ready,
   output logic             req_ready,
   output logic             q_push,
   output q_entry_type      q_entry
);

   logic        keep;
   logic [31:0] low;

   assign low       = req_value[31:0];
   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready && keep;

   // Map the kind to a format class and prepare the magnitude.
   always_comb begin
      keep          = 1'b1;
      q_entry.fmt   = FMT_DEC;
      q_entry.neg   = 1'b0;
      q_entry.nil   = 1'b0;
      q_entry.value = {32'd0, low};
      unique case (req_kind)
         KIND_SDEC: begin
            q_entry.neg = low[31];
            if (low[31]) begin
               q_entry.value = {32'd0, 32'd0 - low};
            end
         end
         KIND_UDEC: begin
            q_entry.fmt = FMT_DEC;
         end
         KIND_HEXL: begin
            q_entry.fmt = FMT_HEXL;
         end
         KIND_HEXU: begin
            q_entry.fmt = FMT_HEXU;
         end
         KIND_PTR: begin
            q_entry.fmt   = FMT_PTR;
            q_entry.nil   = (req_value == 64'd0);
            q_entry.value = req_value;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/i2a_queue.sv =====
// Short register queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"

module i2a_queue
   import i2a_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire q_entry_type push_entry,
   input  wire logic        pop,
   output logic             ready,
   output logic             valid,
   output q_entry_type      head
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   q_entry_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign ready   = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && ready;
   assign do_pop  = pop && valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `I2A_ASSERT(a_queue_fill, clock, reset, count_ff <= CNT_BITS'(QUEUE_DEPTH), "queue overfilled")

endmodule

`default_nettype wire

// ===== src/i2a_back.sv =====
// Back end: converts one queued item to digits and emits its characters one per transfer.
`default_nettype none
`include "assert_macros.svh"

module i2a_back
   import i2a_pkg::*;
#(
   parameter int COUNT_BITS = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire q_entry_type q_head,
   output logic             q_pop,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [7:0]       rsp_char,
   output logic             rsp_last,
   output logic [30:0]      rsp_count
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREFIX = 3'd1;
   localparam logic [2:0] S_CONV   = 3'd2;
   localparam logic [2:0] S_SKIP   = 3'd3;
   localparam logic [2:0] S_DIGITS = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            fmt_ff, fmt_in;
   logic                  neg_ff, neg_in;
   logic                  nil_ff, nil_in;
   logic [63:0]           val_ff, val_in;
   logic [39:0]           bcd_ff, bcd_in;
   logic [5:0]            bit_cnt_ff, bit_cnt_in;
   logic [2:0]            pfx_idx_ff, pfx_idx_in;
   logic [63:0]           dig_ff, dig_in;
   logic [4:0]            rem_ff, rem_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff;
   logic                  rsp_last_ff;
   logic [30:0]           rsp_count_ff, shown;
   logic                  out_free, emit, emit_last;
   logic [7:0]            emit_char;
   logic [2:0]            pfx_last_idx;
   logic [39:0]           bcd_step;

   // One shift-and-add-3 step over all ten decimal digits.
   function automatic logic [39:0] dabble(input logic [39:0] bcd, input logic bit_in);
      logic [39:0] adj;
      adj = bcd;
      for (int d = 0; d < 10; d++) begin
         if (adj[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
         end
      end
      return {adj[38:0], bit_in};
   endfunction

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign q_pop        = (state_ff == S_IDLE) && q_valid;
   assign bcd_step     = dabble(bcd_ff, val_ff[31]);
   assign pfx_last_idx = nil_ff ? 3'd4 : (neg_ff ? 3'd0 : 3'd1);

   // Sequencer for prefix, conversion, leading zero skip and digit output.
   always_comb begin
      state_in   = state_ff;
      fmt_in     = fmt_ff;
      neg_in     = neg_ff;
      nil_in     = nil_ff;
      val_in     = val_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      pfx_idx_in = pfx_idx_ff;
      dig_in     = dig_ff;
      rem_in     = rem_ff;
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_char  = CH_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               fmt_in     = q_head.fmt;
               neg_in     = q_head.neg;
               nil_in     = q_head.nil;
               val_in     = q_head.value;
               bcd_in     = '0;
               bit_cnt_in = 6'd32;
               pfx_idx_in = 3'd0;
               dig_in     = {q_head.value[31:0], 32'd0};
               rem_in     = 5'd8;
               if (q_head.neg || q_head.fmt == FMT_PTR) begin
                  state_in = S_PREFIX;
               end else if (q_head.fmt == FMT_DEC) begin
                  state_in = S_CONV;
               end else begin
                  state_in = S_SKIP;
               end
            end
         end
         S_PREFIX: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_char  = prefix_char(nil_ff, neg_ff, pfx_idx_ff);
               emit_last  = nil_ff && (pfx_idx_ff == pfx_last_idx);
               pfx_idx_in = pfx_idx_ff + 3'd1;
               if (pfx_idx_ff == pfx_last_idx) begin
                  if (nil_ff) begin
                     state_in = S_IDLE;
                  end else if (neg_ff) begin
                     state_in = S_CONV;
                  end else begin
                     dig_in   = val_ff;
                     rem_in   = 5'd16;
                     state_in = S_SKIP;
                  end
               end
            end
         end
         S_CONV: begin
            bcd_in     = bcd_step;
            val_in     = {val_ff[62:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 6'd1;
            if (bit_cnt_ff == 6'd1) begin
               dig_in   = {bcd_step, 24'd0};
               rem_in   = 5'd10;
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            if (dig_ff[63:60] == 4'd0 && rem_ff > 5'd1) begin
               dig_in = {dig_ff[59:0], 4'd0};
               rem_in = rem_ff - 5'd1;
            end else begin
               state_in = S_DIGITS;
            end
         end
         S_DIGITS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = digit_char(fmt_ff, dig_ff[63:60]);
               emit_last = (rem_ff == 5'd1);
               dig_in    = {dig_ff[59:0], 4'd0};
               rem_in    = rem_ff - 5'd1;
               if (rem_ff == 5'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Saturating character count and the value shown on the port.
   assign count_in = (emit && count_ff != '1) ? count_ff + 1'b1 : count_ff;

   generate
      if (COUNT_BITS > 31) begin : g_wide_count
         assign shown = (|count_in[COUNT_BITS-1:31]) ? '1 : count_in[30:0];
      end else begin : g_narrow_count
         assign shown = 31'(count_in);
      end
   endgenerate

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and output payload need no reset.
   always_ff @(posedge clock) begin
      fmt_ff     <= fmt_in;
      neg_ff     <= neg_in;
      nil_ff     <= nil_in;
      val_ff     <= val_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      pfx_idx_ff <= pfx_idx_in;
      dig_ff     <= dig_in;
      rem_ff     <= rem_in;
      if (emit) begin
         rsp_char_ff  <= emit_char;
         rsp_last_ff  <= emit_last;
         rsp_count_ff <= shown;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_count = rsp_count_ff;

   `I2A_ASSERT(a_digits_left, clock, reset, (state_ff == S_DIGITS) |-> (rem_ff != 5'd0), "no digit left in digit output")
   `I2A_ASSERT(a_conv_bits, clock, reset, (state_ff == S_CONV) |-> (bit_cnt_ff != 6'd0), "conversion ran past its bits")
   `I2A_ASSERT(a_last_ends, clock, reset, (emit && emit_last) |=> (state_ff == S_IDLE), "last character did not end the item")

endmodule

`default_nettype wire

// ===== src/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: front end, queue and back end.
// Sequence: after the input transfer an item passes the queue and is popped by the back end,
// which emits any pointer or minus prefix characters; decimal kinds then run a 32-step binary
// to BCD loop, and leading zero digits are skipped before the digits are output.
// Throughput: one character per cycle while output and rsp_tready is high; the back end works
// on one item at a time, while the queue can take up to two further items meanwhile.
// Reset: synchronous, active high; clears the queue, the sequencer and the character count.
`default_nettype none

module integer_to_ascii_formatter
   import i2a_pkg::*;
#(
   parameter int COUNT_BITS = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] value
   input  wire logic [2:0]  req_tuser,   // [2:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] char_code, [38:8] total_count, [39] zero
   output logic             rsp_tlast    // last_char
);

   logic        q_push, q_ready, q_valid, q_pop;
   q_entry_type push_entry, q_head;
   logic [7:0]  rsp_char;
   logic [30:0] rsp_count;

   i2a_front u_front (
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_value (req_tdata),
      .q_ready   (q_ready),
      .req_ready (req_tready),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   i2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .ready      (q_ready),
      .valid      (q_valid),
      .head       (q_head)
   );

   i2a_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast),
      .rsp_count (rsp_count)
   );

   // Pack the result fields into the data bus.
   assign rsp_tdata = {1'b0, rsp_count, rsp_char};

endmodule

`default_nettype wire
